// File: rtl/core/aligned_stack_allocator_assert.svh
// Assertion helpers for the aligned stack allocator checks.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef ALIGNED_STACK_ALLOCATOR_ASSERT_SVH
`define ALIGNED_STACK_ALLOCATOR_ASSERT_SVH

// General property check.
`define ASA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A signal holds while its channel is stalled with valid high.
`define ASA_ASSERT_HOLD(lbl, vld, stl, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && stl) |=> $stable(sig)) else $error(msg);

`endif

// File: rtl/core/asa_pkg.sv
`timescale 1ns / 1ps
package asa_pkg;

  // Default depth of the padding store (bytes in the largest region).
  localparam int unsigned MaxCapacity = 4096;
  // Bytes reserved in front of every block.
  localparam int unsigned HeaderBytes = 1;
  // Largest alignment honored; larger powers of two are clamped.
  localparam int unsigned AlignLimit  = 128;

  localparam int unsigned SizeW  = 13;
  localparam int unsigned OffW   = 12;
  localparam int unsigned AlignW = 10;
  localparam int unsigned BaseW  = 7;
  localparam int unsigned PadW   = 8;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    OpPush   = 2'd0,
    OpPop    = 2'd1,
    OpPopAll = 2'd2,
    OpResize = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StOk     = 3'd0,
    StAlign  = 3'd1,
    StSpace  = 3'd2,
    StBounds = 3'd3,
    StDead   = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCapacity = 2'd0,
    CfgBaseLow  = 2'd1
  } cfg_idx_e;

endpackage

// File: rtl/core/aligned_stack_allocator.sv
`timescale 1ns / 1ps
// Aligned stack allocator: keeps a top offset over a region and a byte of padding per
// offset. Push reserves header-aware aligned space, pop rewinds top to the recorded
// padding, pop-all clears top, resize pushes, pops or keeps the block in place and
// reports the copy length. Each request goes through an input register (where the
// padding store is read) and a result register (where top and the store are updated).
// The result register is loaded from the input register when it is empty or its
// result is taken; one request per cycle is sustained while results are not stalled
// and the clearing pass is over. A store write by the older request is forwarded to a
// read of the same entry. After reset the padding store is cleared one entry per cycle,
// all MAX_CAPACITY entries (4096 by default), with in_stall_o high; configuration
// writes are taken at any time, cfg_ready_o is 1.
module aligned_stack_allocator import asa_pkg::*; #(
  parameter int unsigned MAX_CAPACITY = MaxCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SizeW-1:0]   cfg_data_i,
  // requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [SizeW-1:0]   request_size_i,
  input  logic [SizeW-1:0]   old_size_i,
  input  logic [OffW-1:0]    block_offset_i,
  input  logic               block_present_i,
  input  logic [AlignW-1:0]  alignment_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [OffW-1:0]    result_offset_o,
  output logic               result_present_o,
  output logic [SizeW-1:0]   copy_length_o,
  output logic [SizeW-1:0]   top_o
);

  localparam int unsigned AddrW = $clog2(MAX_CAPACITY);

  // Configuration registers
  logic [SizeW-1:0] cap_q;
  logic [BaseW-1:0] base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= SizeW'(4096);
      base_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgCapacity: cap_q  <= cfg_data_i;
        CfgBaseLow:  base_q <= cfg_data_i[BaseW-1:0];
        default: ;
      endcase
    end
  end

  // Effective capacity: smaller of the register and the store depth
  logic [SizeW-1:0] eff_cap;
  always_comb begin
    if (32'(cap_q) < MAX_CAPACITY) begin
      eff_cap = cap_q;
    end else begin
      eff_cap = SizeW'(MAX_CAPACITY);
    end
  end

  // Clearing pass after reset
  logic             clr_active_q;
  logic [AddrW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AddrW'(MAX_CAPACITY - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // Handshake and stage control
  logic s1_valid_q;
  logic s1_adv;
  logic in_fire;
  logic out_valid_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_active_q || (s1_valid_q && out_valid_q && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;

  // Input register
  op_e               s1_op_q;
  logic [SizeW-1:0]  s1_req_q;
  logic [SizeW-1:0]  s1_old_q;
  logic [OffW-1:0]   s1_blk_q;
  logic              s1_pres_q;
  logic [AlignW-1:0] s1_align_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= op_e'(op_i);
      s1_req_q   <= request_size_i;
      s1_old_q   <= old_size_i;
      s1_blk_q   <= block_offset_i;
      s1_pres_q  <= block_present_i;
      s1_align_q <= alignment_i;
    end
  end

  // Padding store: written by the clearing pass or a successful push
  logic [PadW-1:0]  pad_mem [MAX_CAPACITY];
  logic [PadW-1:0]  pad_rd_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [PadW-1:0]  mem_wdata;
  logic [OffW-1:0]  rd_off;
  logic [AddrW-1:0] rd_addr;
  logic             push_we;
  logic [AddrW-1:0] push_addr;
  logic [PadW-1:0]  push_pad;

  assign rd_off    = block_offset_i - OffW'(1);
  assign rd_addr   = AddrW'(32'(rd_off));
  assign mem_we    = clr_active_q || (s1_adv && push_we);
  assign mem_waddr = clr_active_q ? clr_cnt_q : push_addr;
  assign mem_wdata = clr_active_q ? '0 : push_pad;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pad_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      // forward a same-cycle write to the same entry
      if (mem_we && (mem_waddr == rd_addr)) begin
        pad_rd_q <= mem_wdata;
      end else begin
        pad_rd_q <= pad_mem[rd_addr];
      end
    end
  end

  // Top offset
  logic [SizeW-1:0] top_q;
  logic [SizeW-1:0] top_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
    end else if (s1_adv) begin
      top_q <= top_d;
    end
  end

  // Push arithmetic: padding, aligned offset, capacity check
  logic             align_ok;
  logic [7:0]       a_cl;
  logic [7:0]       a_mask;
  logic [7:0]       addr_lo;
  logic [7:0]       a_mod;
  logic [8:0]       pad0;
  logic [8:0]       need;
  logic [8:0]       pad;
  logic [SizeW:0]   off;
  logic [SizeW+1:0] end_w;
  logic             space_fail;
  logic [SizeW-1:0] off_m1;

  always_comb begin
    align_ok = (s1_align_q != '0) && ((s1_align_q & (s1_align_q - AlignW'(1))) == '0);
    if (32'(s1_align_q) > AlignLimit) begin
      a_cl = 8'(AlignLimit);
    end else begin
      a_cl = s1_align_q[7:0];
    end
    a_mask  = a_cl - 8'd1;
    addr_lo = 8'(base_q) + top_q[7:0];
    a_mod   = addr_lo & a_mask;
    pad0    = (a_mod != '0) ? 9'(a_cl) - 9'(a_mod) : 9'd0;
    need    = 9'(HeaderBytes) - pad0;
    // make room for the header by whole alignment steps
    if (pad0 < 9'(HeaderBytes)) begin
      pad = pad0 + ((need + 9'(a_mask)) & ~9'(a_mask));
    end else begin
      pad = pad0;
    end
    off        = {1'b0, top_q} + (SizeW+1)'(pad);
    end_w      = {1'b0, off} + (SizeW+2)'(s1_req_q);
    space_fail = (end_w > (SizeW+2)'(eff_cap)) || (off >= (SizeW+1)'(eff_cap));
    off_m1     = off[SizeW-1:0] - SizeW'(1);
    push_addr  = AddrW'(32'(off_m1));
    push_pad   = pad[PadW-1:0];
  end

  // Block check and pop arithmetic
  status_e          chk;
  logic [SizeW-1:0] pop_top;

  always_comb begin
    if ((SizeW'(s1_blk_q) >= eff_cap) || (32'(s1_blk_q) < HeaderBytes)) begin
      chk = StBounds;
    end else if (SizeW'(s1_blk_q) >= top_q) begin
      chk = StDead;
    end else begin
      chk = StOk;
    end
    if (OffW'(pad_rd_q) > s1_blk_q) begin
      pop_top = '0;
    end else begin
      pop_top = SizeW'(s1_blk_q - OffW'(pad_rd_q));
    end
  end

  // Operation decode and result
  status_e          st;
  logic [OffW-1:0]  roff;
  logic             rpres;
  logic [SizeW-1:0] rcopy;
  logic             push_sel;
  logic             pop_sel;
  logic             copy_sel;
  logic [SizeW-1:0] short_size;

  assign short_size = (s1_old_q < s1_req_q) ? s1_old_q : s1_req_q;

  always_comb begin
    st       = StOk;
    roff     = '0;
    rpres    = 1'b0;
    rcopy    = '0;
    top_d    = top_q;
    push_we  = 1'b0;
    push_sel = 1'b0;
    pop_sel  = 1'b0;
    copy_sel = 1'b0;
    case (s1_op_q)
      OpPush: push_sel = 1'b1;
      OpPop: pop_sel = s1_pres_q;
      OpPopAll: top_d = '0;
      OpResize: begin
        if (!s1_pres_q) begin
          push_sel = 1'b1;
        end else if (s1_req_q == '0) begin
          pop_sel = 1'b1;
        end else if (chk != StOk) begin
          st = chk;
        end else if (s1_old_q == s1_req_q) begin
          roff  = s1_blk_q;
          rpres = 1'b1;
        end else begin
          push_sel = 1'b1;
          copy_sel = 1'b1;
        end
      end
      default: ;
    endcase
    if (push_sel) begin
      if (!align_ok) begin
        st = StAlign;
      end else if (space_fail) begin
        st = StSpace;
      end else begin
        st      = StOk;
        roff    = off[OffW-1:0];
        rpres   = 1'b1;
        top_d   = end_w[SizeW-1:0];
        push_we = 1'b1;
        rcopy   = copy_sel ? short_size : '0;
      end
    end
    if (pop_sel) begin
      st = chk;
      if (chk == StOk) begin
        top_d = pop_top;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      status_o         <= st;
      result_offset_o  <= roff;
      result_present_o <= rpres;
      copy_length_o    <= rcopy;
      top_o            <= top_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/asa_chk.sv
`timescale 1ns / 1ps
`include "aligned_stack_allocator_assert.svh"
module asa_chk import asa_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [2:0]       status_o,
  input logic [OffW-1:0]  result_offset_o,
  input logic             result_present_o,
  input logic [SizeW-1:0] copy_length_o,
  input logic [SizeW-1:0] top_o
);

  // stalled result keeps its top
  `ASA_ASSERT_HOLD(a_top_hold, out_valid_o, out_stall_i, top_o, "top changed under stall")

  // a returned block only comes with success
  `ASA_ASSERT(a_pres_ok, (out_valid_o && result_present_o) |-> (status_o == StOk), "block with error status")

  // no block means a null offset
  `ASA_ASSERT(a_null_off, (out_valid_o && !result_present_o) |-> (result_offset_o == '0), "offset without block")

  // a returned block lies at or below the new top
  `ASA_ASSERT(a_blk_top, (out_valid_o && result_present_o) |-> (SizeW'(result_offset_o) <= top_o), "block above top")

  // a copy length only comes with a moved block
  `ASA_ASSERT(a_copy_blk, (out_valid_o && (copy_length_o != '0)) |-> result_present_o, "copy without block")

endmodule

bind aligned_stack_allocator asa_chk u_asa_chk (.*);

// File: bench/aligned_stack_allocator_test.sv
`timescale 1ns / 1ps
module aligned_stack_allocator_test;
  import asa_pkg::*;

  localparam int unsigned HalfPeriod = 2;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned NumPhases = 7;

  typedef struct {
    op_e                 op;
    logic [SizeW-1:0]    req;
    logic [SizeW-1:0]    old;
    logic [OffW-1:0]     off;
    logic                pres;
    logic [AlignW-1:0]   align;
  } alloc_req_t;

  typedef struct {
    status_e             status;
    logic [OffW-1:0]     off;
    logic                pres;
    logic [SizeW-1:0]    copy;
    logic [SizeW-1:0]    top;
  } alloc_rsp_t;

  typedef struct {
    alloc_req_t rq;
    bit         typed;
    alloc_rsp_t rsp;
  } directed_row_t;

  typedef struct {
    logic [OffW-1:0]  off;
    logic [SizeW-1:0] size;
  } live_block_t;

  // DUT connections, all inputs known from time zero
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CfgCapacity;
  logic [SizeW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i = OpPush;
  logic [SizeW-1:0]   request_size_i = '0;
  logic [SizeW-1:0]   old_size_i = '0;
  logic [OffW-1:0]    block_offset_i = '0;
  logic               block_present_i = 1'b0;
  logic [AlignW-1:0]  alignment_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic [OffW-1:0]    result_offset_o;
  logic               result_present_o;
  logic [SizeW-1:0]   copy_length_o;
  logic [SizeW-1:0]   top_o;

  // allocator mirror state
  logic [SizeW-1:0]   model_top;
  logic [PadW-1:0]    model_pad [MaxCapacity];
  logic [SizeW-1:0]   model_cap;
  logic [BaseW-1:0]   model_base;

  alloc_rsp_t         awaited_results [$];
  live_block_t        live_blocks [$];
  directed_row_t      directed_rows [$];
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        tx_calm = 0;
  bit                 idle_on = 1'b1;

  aligned_stack_allocator uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .request_size_i   (request_size_i),
    .old_size_i       (old_size_i),
    .block_offset_i   (block_offset_i),
    .block_present_i  (block_present_i),
    .alignment_i      (alignment_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .result_offset_o  (result_offset_o),
    .result_present_o (result_present_o),
    .copy_length_o    (copy_length_o),
    .top_o            (top_o)
  );

  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // allocator prediction
  // ---------------------------------------------------------------------------
  function automatic int unsigned usable_bytes();
    return (model_cap < MaxCapacity) ? int'(model_cap) : MaxCapacity;
  endfunction

  function automatic alloc_rsp_t blank_rsp(status_e st);
    alloc_rsp_t r;
    r.status = st;
    r.off = '0;
    r.pres = 1'b0;
    r.copy = '0;
    r.top = model_top;
    return r;
  endfunction

  // header-aware aligned push; copy is reported only on success
  function automatic alloc_rsp_t reserve_block(int unsigned size, int unsigned align,
                                               int unsigned copy);
    int unsigned a, addr, rem, pad, need, boff;
    if (align == 0 || (align & (align - 1)) != 0) return blank_rsp(StAlign);
    a = (align > AlignLimit) ? AlignLimit : align;
    addr = model_base + model_top;
    rem = addr & (a - 1);
    pad = (rem != 0) ? a - rem : 0;
    if (pad < HeaderBytes) begin
      need = HeaderBytes - pad;
      pad += a * ((need + a - 1) / a);
    end
    boff = model_top + pad;
    if (boff + size > usable_bytes() || boff >= usable_bytes()) return blank_rsp(StSpace);
    model_pad[(boff - 1) % MaxCapacity] = PadW'(pad);
    model_top = SizeW'(boff + size);
    return '{status: StOk, off: OffW'(boff), pres: 1'b1, copy: SizeW'(copy),
             top: model_top};
  endfunction

  function automatic status_e block_status(int unsigned off);
    if (off >= usable_bytes() || off < HeaderBytes) return StBounds;
    if (off >= model_top) return StDead;
    return StOk;
  endfunction

  function automatic alloc_rsp_t release_block(int unsigned off);
    status_e     st;
    int unsigned pad;
    st = block_status(off);
    if (st == StOk) begin
      pad = model_pad[(off - 1) % MaxCapacity];
      model_top = (pad > off) ? '0 : SizeW'(off - pad);
    end
    return blank_rsp(st);
  endfunction

  function automatic alloc_rsp_t predict_alloc(alloc_req_t rq);
    status_e st;
    case (rq.op)
      OpPush: return reserve_block(rq.req, rq.align, 0);
      OpPop: begin
        if (!rq.pres) return blank_rsp(StOk);
        return release_block(rq.off);
      end
      OpPopAll: begin
        model_top = '0;
        return blank_rsp(StOk);
      end
      default: begin
        if (!rq.pres) return reserve_block(rq.req, rq.align, 0);
        if (rq.req == 0) return release_block(rq.off);
        st = block_status(rq.off);
        if (st != StOk) return blank_rsp(st);
        if (rq.old == rq.req)
          return '{status: StOk, off: rq.off, pres: 1'b1, copy: '0, top: model_top};
        return reserve_block(rq.req, rq.align, (rq.old < rq.req) ? rq.old : rq.req);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    alloc_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: unexpected result, status %0d offset %0d top %0d", $realtime,
                   status_o, result_offset_o, top_o);
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status || result_offset_o !== want.off ||
            result_present_o !== want.pres || copy_length_o !== want.copy ||
            top_o !== want.top) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: mismatch, expected status %0d offset %0d present %0d copy %0d top %0d",
                     $realtime, want.status, want.off, want.pres, want.copy, want.top);
            $display("%0t: mismatch, actual   status %0d offset %0d present %0d copy %0d top %0d",
                     $realtime, status_o, result_offset_o, result_present_o,
                     copy_length_o, top_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result-side backpressure: random bursts with calm stretches
  // ---------------------------------------------------------------------------
  initial begin : rx_stall
    int unsigned burst, calm;
    burst = 0;
    calm = 0;
    forever begin
      @(posedge clk_i);
      if (!idle_on) begin
        burst = 0;
      end else if (burst == 0) begin
        if (calm != 0) calm--;
        else if ($urandom_range(0, 99) < 4) calm = $urandom_range(30, 120);
        else if ($urandom_range(0, 99) < 10) burst = $urandom_range(1, 15);
      end
      if (burst != 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  function automatic int unsigned sender_gap();
    if (!idle_on) return 0;
    if (tx_calm != 0) begin
      tx_calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      tx_calm = $urandom_range(20, 80);
      return 0;
    end
    if ($urandom_range(0, 99) < 12) return $urandom_range(1, 15);
    return 0;
  endfunction

  function automatic logic [SizeW-1:0] rand_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return SizeW'($urandom_range(0, 48));
    if (r < 90) return SizeW'($urandom_range(0, 600));
    if (r < 97) return SizeW'($urandom_range(0, 4096));
    return SizeW'($urandom_range(0, 8191));
  endfunction

  function automatic logic [AlignW-1:0] rand_align();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return AlignW'(1 << $urandom_range(0, AlignW - 1));
    if (r < 88) return '0;
    return AlignW'($urandom_range(0, 1023));
  endfunction

  // drive one request, wait for it to be taken, record its prediction
  task automatic send_request(alloc_req_t rq, bit typed, alloc_rsp_t typed_rsp,
                              output alloc_rsp_t seen);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      op_i <= 2'($urandom_range(0, 3));
      request_size_i <= SizeW'($urandom_range(0, 8191));
      block_offset_i <= OffW'($urandom_range(0, 4095));
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= rq.op;
    request_size_i <= rq.req;
    old_size_i <= rq.old;
    block_offset_i <= rq.off;
    block_present_i <= rq.pres;
    alignment_i <= rq.align;
    do @(posedge clk_i); while (in_stall_o);
    seen = predict_alloc(rq);
    awaited_results.push_back(typed ? typed_rsp : seen);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // both registers back to back, valid dropped after the second
  task automatic set_config(logic [SizeW-1:0] cap, logic [BaseW-1:0] base);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgCapacity;
    cfg_data_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_cap = cap;
    cfg_index_i <= CfgBaseLow;
    cfg_data_i <= {6'($urandom_range(0, 63)), base};
    do @(posedge clk_i); while (!cfg_ready_o);
    model_base = base;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(op_e op, int req, int old, int off, bit pres, int align,
                         bit typed, status_e st, int roff, bit rpres, int copy, int top);
    directed_row_t row;
    row.rq = '{op: op, req: SizeW'(req), old: SizeW'(old), off: OffW'(off), pres: pres,
               align: AlignW'(align)};
    row.typed = typed;
    row.rsp = '{status: st, off: OffW'(roff), pres: rpres, copy: SizeW'(copy),
                top: SizeW'(top)};
    directed_rows.push_back(row);
  endtask

  // mostly well-formed push/pop traffic over live blocks, with some noise
  task automatic make_request(output alloc_req_t rq);
    int unsigned pick, sel;
    bit          have;
    live_block_t blk;
    rq.op = OpPush;
    rq.req = rand_size();
    rq.old = rand_size();
    rq.off = OffW'($urandom_range(0, 4095));
    rq.pres = 1'($urandom_range(0, 1));
    rq.align = rand_align();
    have = live_blocks.size() != 0;
    blk = '{off: '0, size: '0};
    if (have) begin
      sel = ($urandom_range(0, 99) < 65) ? live_blocks.size() - 1
                                         : $urandom_range(0, live_blocks.size() - 1);
      blk = live_blocks[sel];
    end
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      rq.op = OpPush;
    end else if (pick < 68) begin
      rq.op = OpPop;
      rq.pres = ($urandom_range(0, 9) != 0);
      if (have && $urandom_range(0, 9) != 0) rq.off = blk.off;
    end else if (pick < 72) begin
      rq.op = OpPopAll;
    end else begin
      rq.op = OpResize;
      rq.pres = ($urandom_range(0, 6) != 0);
      if (have && $urandom_range(0, 9) != 0) begin
        rq.off = blk.off;
        if ($urandom_range(0, 4) != 0) rq.old = blk.size;
      end
      sel = $urandom_range(0, 99);
      if (sel < 15) rq.req = '0;
      else if (sel < 30) rq.req = rq.old;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned   phase_cap [NumPhases];
    int unsigned   phase_base [NumPhases];
    int unsigned   phase_len [NumPhases];
    alloc_req_t    rq;
    alloc_rsp_t    seen;
    directed_row_t row;

    phase_cap = '{4096, 4096, 200, 0, 8191, 4096, 4096};
    phase_base = '{0, 127, 5, 64, 1, 0, 0};
    phase_len = '{300, 300, 250, 60, 300, 240, 200};
    phase_cap[5] = $urandom_range(1, 4096);
    phase_base[5] = $urandom_range(0, 127);
    phase_base[6] = $urandom_range(0, 127);

    model_top = '0;
    model_cap = SizeW'(MaxCapacity);
    model_base = '0;
    foreach (model_pad[i]) model_pad[i] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset config, capacity 4096 and base 0
    add_row(OpPopAll,   0,    0,    0, 1,    0, 1, StOk,     0, 0, 0,    0);
    add_row(OpPush,     8,    0,    0, 0,    0, 1, StAlign,  0, 0, 0,    0);
    add_row(OpPush,     8,    0,    0, 0,    3, 1, StAlign,  0, 0, 0,    0);
    add_row(OpPush,     8,    0,    0, 0,    1, 1, StOk,     1, 1, 0,    9);
    add_row(OpPush,    16,    0,    0, 0,   16, 0, StOk,     0, 0, 0,    0);
    add_row(OpPush,  4096,    0,    0, 0,    1, 1, StSpace,  0, 0, 0,   32);
    // alignment above the clamp
    add_row(OpPush,     8,    0,    0, 0,  512, 0, StOk,     0, 0, 0,    0);
    add_row(OpPush,     8,    0,    0, 0, 1023, 1, StAlign,  0, 0, 0,  136);
    add_row(OpPop,      0,    0, 4095, 0,    0, 1, StOk,     0, 0, 0,  136);
    add_row(OpPop,      0,    0,    0, 1,    0, 1, StBounds, 0, 0, 0,  136);
    add_row(OpPop,      0,    0, 4095, 1,    0, 1, StDead,   0, 0, 0,  136);
    // resize: null, same size, grow, to zero, failed push, bad block
    add_row(OpResize,   4,    9,   77, 0,    4, 0, StOk,     0, 0, 0,    0);
    add_row(OpResize,   4,    4,  140, 1,    4, 1, StOk,   140, 1, 0,  144);
    add_row(OpResize,  10,    4,  140, 1,    8, 0, StOk,     0, 0, 0,    0);
    add_row(OpResize,   0,   10,  152, 1,    8, 0, StOk,     0, 0, 0,    0);
    add_row(OpResize, 8191,   4,  140, 1,    1, 1, StSpace,  0, 0, 0,  144);
    add_row(OpResize,   5,    3,    0, 1,    1, 1, StBounds, 0, 0, 0,  144);
    add_row(OpResize,   5,    3, 3000, 1,    1, 1, StDead,   0, 0, 0,  144);
    add_row(OpResize,   5,    3,    9, 0,    0, 1, StAlign,  0, 0, 0,  144);
    add_row(OpPop,      0,    0,  140, 1,    0, 0, StOk,     0, 0, 0,    0);
    add_row(OpPop,      0,    0,  128, 1,    0, 0, StOk,     0, 0, 0,    0);
    // fill to the very end of the region
    add_row(OpPush,  4063,    0,    0, 0,    1, 0, StOk,     0, 0, 0,    0);
    add_row(OpPush,     0,    0,    0, 0,    1, 1, StSpace,  0, 0, 0, 4096);
    add_row(OpPop,      0,    0,   33, 1,    0, 0, StOk,     0, 0, 0,    0);
    // pop at an offset whose padding entry was never written
    add_row(OpPop,      0,    0,   20, 1,    0, 0, StOk,     0, 0, 0,    0);
    add_row(OpPopAll,   0,    0,    0, 0,    0, 1, StOk,     0, 0, 0,    0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.rq, row.typed, row.rsp, seen);
    end

    // random phases; top is kept across a capacity change on purpose
    for (int p = 0; p < NumPhases; p++) begin
      hold_until_drained();
      set_config(SizeW'(phase_cap[p]), BaseW'(phase_base[p]));
      if (p == NumPhases - 1) idle_on = 1'b0;
      for (int n = 0; n < phase_len[p]; n++) begin
        if (p == 0 && n == phase_len[p] / 2) hold_until_drained();
        make_request(rq);
        send_request(rq, 1'b0, seen, seen);
        if (seen.pres && !(rq.op == OpResize && rq.pres && rq.old == rq.req))
          live_blocks.push_back('{off: seen.off, size: rq.req});
        live_blocks = live_blocks.find(b) with (b.off < model_top);
      end
    end

    hold_until_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/asa_pkg.sv
rtl/core/aligned_stack_allocator.sv
rtl/core/asa_chk.sv
bench/aligned_stack_allocator_test.sv
